/* rtl/arps_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// arps_pkg
// Shared widths, codes, register defaults and control types of the actuator
// reed-pulse simulator.
// ----------------------------------------------------------------------------
package arps_pkg;

  // item field widths
  localparam int ACTION_BITS = 3;
  localparam int DIR_BITS    = 2;
  localparam int DUTY_BITS   = 8;
  localparam int NOISE_BITS  = 8;
  localparam int JUMP_BITS   = 24;
  localparam int PULSE_BITS  = 2;

  // register widths
  localparam int RATE_BITS    = 10;
  localparam int SPACING_BITS = 20;
  localparam int LAG_BITS     = 24;
  localparam int TRAVEL_BITS  = 23;

  // configuration port
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 24;

  // pulse countdown width
  localparam int COUNT_BITS = 32;

  // action codes
  localparam logic [ACTION_BITS-1:0] ACT_TICK  = 3'd0;
  localparam logic [ACTION_BITS-1:0] ACT_DRIVE = 3'd1;
  localparam logic [ACTION_BITS-1:0] ACT_JAM   = 3'd2;
  localparam logic [ACTION_BITS-1:0] ACT_NOISE = 3'd3;
  localparam logic [ACTION_BITS-1:0] ACT_JUMP  = 3'd4;

  // register indexes
  localparam logic [CFG_INDEX_BITS-1:0] REG_RATE    = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SPACING = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_LAG     = 2'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_TRAVEL  = 2'd3;

  // register reset values
  localparam logic [RATE_BITS-1:0]    RATE_RESET    = 10'd40;
  localparam logic [SPACING_BITS-1:0] SPACING_RESET = 20'd200;
  localparam logic [LAG_BITS-1:0]     LAG_RESET     = 24'd50000;
  localparam logic [TRAVEL_BITS-1:0]  TRAVEL_RESET  = 23'd1000;

  // direction encoding (two's complement -1 / 0 / +1)
  localparam logic [DIR_BITS-1:0] DIR_OFF     = 2'b00;
  localparam logic [DIR_BITS-1:0] DIR_EXTEND  = 2'b01;
  localparam logic [DIR_BITS-1:0] DIR_RETRACT = 2'b11;

  // countdown that never expires, saturation of the move timer
  localparam logic [COUNT_BITS-1:0] NEVER_US    = 32'hFFFF_FFFF;
  localparam logic [LAG_BITS-1:0]   ELAPSED_MAX = 24'hFF_FFFF;

  // lower bound of the upper hard stop
  localparam logic [31:0] TRAVEL_MIN = 32'd10;

  // interval arithmetic: milli_hz = rate * duty * 1000 / 255, then 1e9 / milli_hz
  localparam int PROD_BITS        = RATE_BITS + DUTY_BITS;
  localparam int SCALED_BITS      = 28;
  localparam logic [SCALED_BITS-1:0] MILLI_SCALE = 28'd1000;
  localparam int RECIP_BITS       = 32;
  localparam logic [RECIP_BITS-1:0] RECIP_255 = 32'h8080_8081;
  localparam int RECIP_PROD_BITS  = SCALED_BITS + RECIP_BITS;
  localparam int RECIP_SHIFT      = 39;
  localparam int MILLI_BITS       = 20;
  localparam int DIVIDEND_BITS    = 30;
  localparam logic [DIVIDEND_BITS-1:0] DIVIDEND = 30'd1000000000;
  localparam int DIV_STEPS        = DIVIDEND_BITS;
  localparam int DIV_CNT_BITS     = $clog2(DIV_STEPS);

  // controller to datapath commands
  typedef struct packed {
    logic load_item;
    logic exec;
    logic mul_rate;
    logic mul_scale;
    logic mul_recip;
    logic div_init;
    logic div_step;
    logic write_interval;
    logic load_out;
  } arps_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic need_interval;
    logic div_last;
    logic out_free;
  } arps_status_t;

endpackage
`default_nettype wire

/* rtl/arps_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// arps_if
// Valid/ready channels of the simulator: input items, results and
// configuration writes.
// ----------------------------------------------------------------------------

// input item channel
interface arps_item_if;
  import arps_pkg::*;
  logic                          valid;
  logic                          ready;
  logic [ACTION_BITS-1:0]        action;
  logic signed [DIR_BITS-1:0]    drive_dir;
  logic [DUTY_BITS-1:0]          drive_duty;
  logic                          jam_value;
  logic [NOISE_BITS-1:0]         noise_count;
  logic signed [JUMP_BITS-1:0]   jump_position;

  modport source (
    output valid, action, drive_dir, drive_duty, jam_value, noise_count, jump_position,
    input  ready
  );
  modport sink (
    input  valid, action, drive_dir, drive_duty, jam_value, noise_count, jump_position,
    output ready
  );
endinterface

// result channel
interface arps_result_if #(
  parameter int POSITION_BITS = 23
);
  import arps_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [PULSE_BITS-1:0]    pulses_emitted;
  logic [POSITION_BITS-1:0] true_position;
  logic [NOISE_BITS-1:0]    noise_pending;

  modport source (
    output valid, pulses_emitted, true_position, noise_pending,
    input  ready
  );
  modport sink (
    input  valid, pulses_emitted, true_position, noise_pending,
    output ready
  );
endinterface

// configuration write channel
interface arps_cfg_if;
  import arps_pkg::*;
  logic                      valid;
  logic                      ready;
  logic [CFG_INDEX_BITS-1:0] index;
  logic [CFG_DATA_BITS-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

/* rtl/actuator_reed_pulse_simulator_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// actuator_reed_pulse_simulator_core
// Motor-driven actuator with reed-switch pulse output for hardware-in-the-loop
// testing: carriage position, drive, jam, start lag, end stops and noise.
// ----------------------------------------------------------------------------
// Usage:
//   item   - one transaction per event: a one-microsecond tick, a drive
//            command, a jam change, a noise burst or a position jump.
//   result - one transaction per item: pulses of the item, carriage
//            position and noise pulses still pending.
//   cfg    - register writes (rate, noise spacing, start lag, travel); always
//            ready, to be written only while no item is in flight.
// Sequence: most items go from intake through the state update to the result.
//   An item that (re)loads the motion interval - a tick that steps the carriage,
//   a new move or a jam release - also passes three multiply stages and a
//   one-bit-per-cycle restoring divide of 1e9 by the pulse rate (30 steps).
// Throughput: one item at a time; the next item is taken in the cycle after
//   its result enters the output register.
// Reset: synchronous; clears the actuator state and loads register defaults.
// Stall: a result waits in the output register; the block finishes the next
//   item and holds it until the register frees up.
// ----------------------------------------------------------------------------
module actuator_reed_pulse_simulator_core #(
  parameter int POSITION_BITS = 23
) (
  input wire logic       clk,
  input wire logic       rst,
  arps_item_if.sink      item,
  arps_result_if.source  result,
  arps_cfg_if.sink       cfg
);
  import arps_pkg::*;

  arps_cmd_t    cmd;
  arps_status_t status;

  // configuration writes are taken at once
  assign cfg.ready = 1'b1;

  // sequencer
  arps_controller u_controller (
    .clk      (clk),
    .rst      (rst),
    .in_valid (item.valid),
    .in_ready (item.ready),
    .status   (status),
    .cmd      (cmd)
  );

  // state and arithmetic
  arps_datapath #(
    .POSITION_BITS (POSITION_BITS)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .action         (item.action),
    .drive_dir      (item.drive_dir),
    .drive_duty     (item.drive_duty),
    .jam_value      (item.jam_value),
    .noise_count    (item.noise_count),
    .jump_position  (item.jump_position),
    .cfg_write      (cfg.valid),
    .cfg_index      (cfg.index),
    .cfg_data       (cfg.data),
    .out_valid      (result.valid),
    .out_ready      (result.ready),
    .pulses_emitted (result.pulses_emitted),
    .true_position  (result.true_position),
    .noise_pending  (result.noise_pending)
  );

endmodule
`default_nettype wire

/* rtl/arps_controller.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// arps_controller
// Sequencer of the simulator: item intake, state update, interval
// computation (multiplies and iterative divide) and result hand-off.
// ----------------------------------------------------------------------------
module arps_controller (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire arps_pkg::arps_status_t status,
  output arps_pkg::arps_cmd_t        cmd
);
  import arps_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_MUL_RATE,
    S_MUL_SCALE,
    S_MUL_RECIP,
    S_DIV_INIT,
    S_DIV,
    S_WRITE,
    S_DONE
  } state_t;

  state_t state;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) state <= S_EXEC;
        end
        S_EXEC: begin
          state <= status.need_interval ? S_MUL_RATE : S_DONE;
        end
        S_MUL_RATE:  state <= S_MUL_SCALE;
        S_MUL_SCALE: state <= S_MUL_RECIP;
        S_MUL_RECIP: state <= S_DIV_INIT;
        S_DIV_INIT:  state <= S_DIV;
        S_DIV: begin
          if (status.div_last) state <= S_WRITE;
        end
        S_WRITE: state <= S_DONE;
        S_DONE: begin
          if (status.out_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // command decode
  always_comb begin
    in_ready           = (state == S_IDLE);
    cmd                = '0;
    cmd.load_item      = (state == S_IDLE) && in_valid;
    cmd.exec           = (state == S_EXEC);
    cmd.mul_rate       = (state == S_MUL_RATE);
    cmd.mul_scale      = (state == S_MUL_SCALE);
    cmd.mul_recip      = (state == S_MUL_RECIP);
    cmd.div_init       = (state == S_DIV_INIT);
    cmd.div_step       = (state == S_DIV);
    cmd.write_interval = (state == S_WRITE);
    cmd.load_out       = (state == S_DONE) && status.out_free;
  end

endmodule
`default_nettype wire

/* rtl/arps_datapath.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// arps_datapath
// Actuator state, configuration registers, tick and command update, pulse
// interval arithmetic and the result register.
// ----------------------------------------------------------------------------
module arps_datapath #(
  parameter int POSITION_BITS = 23
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire arps_pkg::arps_cmd_t                    cmd,
  output arps_pkg::arps_status_t                      status,
  // item fields
  input  wire logic [arps_pkg::ACTION_BITS-1:0]       action,
  input  wire logic signed [arps_pkg::DIR_BITS-1:0]   drive_dir,
  input  wire logic [arps_pkg::DUTY_BITS-1:0]         drive_duty,
  input  wire logic                                   jam_value,
  input  wire logic [arps_pkg::NOISE_BITS-1:0]        noise_count,
  input  wire logic signed [arps_pkg::JUMP_BITS-1:0]  jump_position,
  // configuration write
  input  wire logic                                   cfg_write,
  input  wire logic [arps_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
  input  wire logic [arps_pkg::CFG_DATA_BITS-1:0]     cfg_data,
  // result
  output logic                                        out_valid,
  input  wire logic                                   out_ready,
  output logic [arps_pkg::PULSE_BITS-1:0]             pulses_emitted,
  output logic [POSITION_BITS-1:0]                    true_position,
  output logic [arps_pkg::NOISE_BITS-1:0]             noise_pending
);
  import arps_pkg::*;

  localparam logic [31:0] POS_MAX = 32'((64'd1 << POSITION_BITS) - 64'd1);

  // upper hard stop for a given travel setting
  function automatic logic [31:0] stop_of(input logic [TRAVEL_BITS-1:0] travel);
    logic [31:0] t;
    t = 32'(travel);
    if (t < TRAVEL_MIN) t = TRAVEL_MIN;
    if (t > POS_MAX) t = POS_MAX;
    return t;
  endfunction

  // configuration registers
  logic [RATE_BITS-1:0]    pulses_per_second;
  logic [SPACING_BITS-1:0] noise_spacing_us;
  logic [LAG_BITS-1:0]     startup_lag_us;
  logic [TRAVEL_BITS-1:0]  travel_counts;

  // actuator state
  logic [POSITION_BITS-1:0] position;
  logic [DIR_BITS-1:0]      direction;
  logic [DUTY_BITS-1:0]     duty_level;
  logic [COUNT_BITS-1:0]    pulse_countdown;
  logic [NOISE_BITS-1:0]    noise_remaining;
  logic [SPACING_BITS-1:0]  noise_countdown;
  logic [LAG_BITS-1:0]      move_elapsed;
  logic                     jam_flag;

  // latched item
  logic [ACTION_BITS-1:0] item_action;
  logic [DIR_BITS-1:0]    item_dir;
  logic [DUTY_BITS-1:0]   item_duty;
  logic                   item_jam;
  logic [NOISE_BITS-1:0]  item_noise;
  logic [JUMP_BITS-1:0]   item_jump;

  // pulses of the current item
  logic [PULSE_BITS-1:0] fired;

  // interval arithmetic
  logic [PROD_BITS-1:0]       rate_prod;
  logic [SCALED_BITS-1:0]     scaled;
  logic [RECIP_PROD_BITS-1:0] recip_prod;
  logic [MILLI_BITS-1:0]      milli;
  logic [DIVIDEND_BITS-1:0]   quo;
  logic [MILLI_BITS-1:0]      rem;
  logic [DIV_CNT_BITS-1:0]    div_cnt;
  logic [MILLI_BITS:0]        rem_shifted;
  logic                       quo_bit;

  // tick and command decode
  logic [31:0]             stop_limit;
  logic [31:0]             cfg_stop;
  logic [31:0]             jump_sel;
  logic [SPACING_BITS-1:0] nc_dec;
  logic [COUNT_BITS-1:0]   pc_dec;
  logic [LAG_BITS-1:0]     me_inc;
  logic                    noise_fire;
  logic                    at_stop;
  logic                    motion_fire;
  logic [DIR_BITS-1:0]     dir_new;
  logic                    drive_off;
  logic                    new_move;

  // tick: countdowns first, then noise pulse, then motion pulse
  always_comb begin
    stop_limit  = stop_of(travel_counts);
    cfg_stop    = stop_of(cfg_data[TRAVEL_BITS-1:0]);
    nc_dec      = (noise_countdown != '0) ? noise_countdown - SPACING_BITS'(1)
                                          : noise_countdown;
    pc_dec      = (pulse_countdown != '0 && pulse_countdown != NEVER_US)
                  ? pulse_countdown - COUNT_BITS'(1) : pulse_countdown;
    me_inc      = (move_elapsed != ELAPSED_MAX) ? move_elapsed + LAG_BITS'(1)
                                                : move_elapsed;
    noise_fire  = (noise_remaining != '0) && (nc_dec == '0);
    at_stop     = (direction == DIR_EXTEND) ? (32'(position) >= stop_limit)
                                            : (position == '0);
    motion_fire = (direction != DIR_OFF) && (duty_level != '0) && !jam_flag &&
                  (me_inc >= startup_lag_us) && !at_stop && (pc_dec == '0);
  end

  // drive decode, negative patterns mean retract
  always_comb begin
    if (item_dir == DIR_OFF)  dir_new = DIR_OFF;
    else if (item_dir[1])     dir_new = DIR_RETRACT;
    else                      dir_new = DIR_EXTEND;
    drive_off = (dir_new == DIR_OFF) || (item_duty == '0);
    new_move  = !drive_off && (dir_new != direction);
  end

  // position jump clamped to zero through the stop
  always_comb begin
    if (item_jump[JUMP_BITS-1])               jump_sel = '0;
    else if (32'(item_jump) > stop_limit)     jump_sel = stop_limit;
    else                                      jump_sel = 32'(item_jump);
  end

  // interval needed after this item
  always_comb begin
    case (item_action)
      ACT_TICK:  status.need_interval = motion_fire;
      ACT_DRIVE: status.need_interval = new_move;
      ACT_JAM:   status.need_interval = !item_jam;
      default:   status.need_interval = 1'b0;
    endcase
    status.div_last = (div_cnt == '0);
    status.out_free = !out_valid || out_ready;
  end

  // divider step: one quotient bit per cycle
  always_comb begin
    rem_shifted = {rem, quo[DIVIDEND_BITS-1]};
    quo_bit     = (rem_shifted >= {1'b0, milli});
  end

  // item latch
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_action <= action;
      item_dir    <= drive_dir;
      item_duty   <= drive_duty;
      item_jam    <= jam_value;
      item_noise  <= noise_count;
      item_jump   <= jump_position;
    end
  end

  // actuator state and configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pulses_per_second <= RATE_RESET;
      noise_spacing_us  <= SPACING_RESET;
      startup_lag_us    <= LAG_RESET;
      travel_counts     <= TRAVEL_RESET;
      position          <= '0;
      direction         <= DIR_OFF;
      duty_level        <= '0;
      pulse_countdown   <= '0;
      noise_remaining   <= '0;
      noise_countdown   <= '0;
      move_elapsed      <= '0;
      jam_flag          <= 1'b0;
    end else begin
      if (cmd.exec) begin
        case (item_action)
          ACT_TICK: begin
            pulse_countdown <= pc_dec;
            move_elapsed    <= me_inc;
            if (noise_fire) begin
              noise_remaining <= noise_remaining - NOISE_BITS'(1);
              noise_countdown <= noise_spacing_us;
            end else begin
              noise_countdown <= nc_dec;
            end
            if (motion_fire) begin
              if (direction == DIR_EXTEND) position <= position + POSITION_BITS'(1);
              else                         position <= position - POSITION_BITS'(1);
            end
          end
          ACT_DRIVE: begin
            if (drive_off) begin
              direction  <= DIR_OFF;
              duty_level <= '0;
            end else if (new_move) begin
              direction    <= dir_new;
              duty_level   <= item_duty;
              move_elapsed <= '0;
            end else begin
              duty_level <= item_duty;
            end
          end
          ACT_JAM: begin
            jam_flag <= item_jam;
          end
          ACT_NOISE: begin
            noise_remaining <= item_noise;
            noise_countdown <= '0;
          end
          ACT_JUMP: begin
            position <= POSITION_BITS'(jump_sel);
          end
          default: begin
          end
        endcase
      end
      // reload the motion countdown from the divider
      if (cmd.write_interval) begin
        pulse_countdown <= (milli == '0) ? NEVER_US : COUNT_BITS'(quo);
      end
      // register writes
      if (cfg_write) begin
        case (cfg_index)
          REG_RATE:    pulses_per_second <= cfg_data[RATE_BITS-1:0];
          REG_SPACING: noise_spacing_us  <= cfg_data[SPACING_BITS-1:0];
          REG_LAG:     startup_lag_us    <= cfg_data[LAG_BITS-1:0];
          REG_TRAVEL: begin
            travel_counts <= cfg_data[TRAVEL_BITS-1:0];
            if (32'(position) > cfg_stop) position <= POSITION_BITS'(cfg_stop);
          end
          default: begin
          end
        endcase
      end
    end
  end

  // pulse count of the item
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      if (item_action == ACT_TICK) begin
        fired <= PULSE_BITS'(noise_fire) + PULSE_BITS'(motion_fire);
      end else begin
        fired <= '0;
      end
    end
  end

  // interval: multiply chain, then restoring divide of 1e9 by milli_hz
  always_ff @(posedge clk) begin
    if (cmd.mul_rate) begin
      rate_prod <= PROD_BITS'(pulses_per_second) * PROD_BITS'(duty_level);
    end
    if (cmd.mul_scale) begin
      scaled <= SCALED_BITS'(rate_prod) * MILLI_SCALE;
    end
    if (cmd.mul_recip) begin
      recip_prod <= RECIP_PROD_BITS'(scaled) * RECIP_PROD_BITS'(RECIP_255);
    end
    if (cmd.div_init) begin
      milli <= recip_prod[RECIP_SHIFT +: MILLI_BITS];
      quo   <= DIVIDEND;
      rem   <= '0;
    end
    if (cmd.div_step) begin
      quo <= {quo[DIVIDEND_BITS-2:0], quo_bit};
      rem <= quo_bit ? MILLI_BITS'(rem_shifted - {1'b0, milli})
                     : MILLI_BITS'(rem_shifted);
    end
  end

  // divide step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      div_cnt <= '0;
    end else if (cmd.div_init) begin
      div_cnt <= DIV_CNT_BITS'(DIV_STEPS - 1);
    end else if (cmd.div_step && div_cnt != '0) begin
      div_cnt <= div_cnt - DIV_CNT_BITS'(1);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      pulses_emitted <= fired;
      true_position  <= position;
      noise_pending  <= noise_remaining;
    end
  end

endmodule
`default_nettype wire
